FILE: design/edfa_pkg.sv
`default_nettype none
package edfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PW = 66;
  localparam int AXW = PW - FRAC_BITS + 2;
  localparam int SW = 70;

  typedef logic signed [SW-1:0] wide_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_t;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SAT = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  function automatic sat_t sat32(input wide_t v);
    sat_t res;
    res.hit = !((&v[SW-1:31]) || !(|v[SW-1:31]));
    res.val = res.hit ? (v[SW-1] ? 32'sh80000000 : 32'sh7fffffff) : v[31:0];
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/edge_diffusion_flux_assembly.sv
// Edge diffusion flux assembly. Each edge comes as two requests: a left-node request
// (in_tuser 0) is stored in registers and gives no result; a right-node request
// (in_tuser 1) brings the area vector and gives one result with the matrix factor,
// the diffusive flux with the over-relaxed non-orthogonal correction, and a status
// (0 ok, 1 saturated, 2 zero area dot distance). All values are signed Q16.16, but
// diff_coeff is unsigned. A right request holds in_tready low until its result is
// in the output register, longer while the previous result still waits there: one
// 33x33 multiplier is reused for every product and the division is a 64-step
// restoring loop. in_tready is low while an edge is in work; a finished result waits
// in the output register while the next request is taken.
`default_nettype none
module edge_diffusion_flux_assembly (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // pos_x, pos_y, pos_z, grad_x, grad_y, grad_z, scalar_value, diff_coeff, area_x,
  // area_y, area_z, zero pad
  input  wire logic [351:0] in_tdata,
  // kind
  input  wire logic         in_tuser,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // matrix_factor, diff_flux
  output      logic [63:0]  out_tdata,
  // status
  output      logic [1:0]   out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_wdata
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ASQ = 4'd1;
  localparam logic [3:0] ST_ADX = 4'd2;
  localparam logic [3:0] ST_CHK = 4'd3;
  localparam logic [3:0] ST_DIV = 4'd4;
  localparam logic [3:0] ST_R = 4'd5;
  localparam logic [3:0] ST_LHS = 4'd6;
  localparam logic [3:0] ST_K = 4'd7;
  localparam logic [3:0] ST_T = 4'd8;
  localparam logic [3:0] ST_N = 4'd9;
  localparam logic [3:0] ST_DQ = 4'd10;
  localparam logic [3:0] ST_OUT = 4'd11;

  localparam int F = edfa_pkg::FRAC_BITS;

  logic [3:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic [1:0] j_r, j_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] dims_r;

  logic signed [31:0] lpos_r [3];
  logic signed [31:0] lgrad_r [3];
  logic signed [31:0] lval_r;
  logic [30:0]        lcoeff_r;

  logic signed [31:0] a_r [3];
  logic signed [32:0] d_r [3];
  logic signed [31:0] g_r [3];
  logic [30:0]        visc_r;
  logic signed [32:0] dq_r;

  logic [63:0]                  asq_r, asq_nxt;
  logic signed [edfa_pkg::AXW-1:0] axdx_r, axdx_nxt, nsum_r, nsum_nxt;
  logic [63:0]                  dvd_r, dvd_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic signed [31:0]           r_r, r_nxt, lhs_r, lhs_nxt, k_r, k_nxt, t_r, t_nxt;
  logic signed [31:0]           flux_r, flux_nxt;
  logic                         sat_r, sat_nxt;
  logic [1:0]                   stat_r, stat_nxt;
  logic signed [edfa_pkg::PW-1:0] prod_r, prod_nxt, shp;

  logic signed [32:0] mul_a, mul_b;
  logic [1:0]         last_j;
  logic [64:0]        rem_sh;
  logic [64:0]        rem_sub;
  edfa_pkg::wide_t    sat_in;
  edfa_pkg::sat_t     sat_o;
  logic               in_acc;

  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign last_j = (dims_r == 2'd2) ? 2'd1 : 2'd2;
  assign shp = prod_r >>> F;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_ASQ: begin
        mul_a = 33'(a_r[j_r]);
        mul_b = 33'(a_r[j_r]);
      end
      ST_ADX: begin
        mul_a = 33'(a_r[j_r]);
        mul_b = d_r[j_r];
      end
      ST_LHS: begin
        mul_a = {2'b00, visc_r};
        mul_b = 33'(r_r);
      end
      ST_K: begin
        mul_a = 33'(r_r);
        mul_b = d_r[j_r];
      end
      ST_T: begin
        mul_a = {2'b00, visc_r};
        mul_b = 33'(k_r);
      end
      ST_N: begin
        mul_a = 33'(t_r);
        mul_b = 33'(g_r[j_r]);
      end
      ST_DQ: begin
        mul_a = 33'(lhs_r);
        mul_b = dq_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rem_sh = {rem_r, dvd_r[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    case (state_r)
      ST_LHS: sat_in = -edfa_pkg::wide_t'(shp);
      ST_K: sat_in = edfa_pkg::wide_t'(a_r[j_r]) - edfa_pkg::wide_t'(shp);
      ST_T: sat_in = edfa_pkg::wide_t'(shp);
      ST_DQ: sat_in = edfa_pkg::wide_t'(shp) - edfa_pkg::wide_t'(nsum_r);
      default: sat_in = '0;
    endcase
  end

  assign sat_o = edfa_pkg::sat32(sat_in);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    j_nxt = j_r;
    cnt_nxt = cnt_r;
    asq_nxt = asq_r;
    axdx_nxt = axdx_r;
    nsum_nxt = nsum_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    r_nxt = r_r;
    lhs_nxt = lhs_r;
    k_nxt = k_r;
    t_nxt = t_r;
    flux_nxt = flux_r;
    sat_nxt = sat_r;
    stat_nxt = stat_r;
    prod_nxt = mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser) begin
          state_nxt = ST_ASQ;
          phase_nxt = 1'b0;
          j_nxt = '0;
          asq_nxt = '0;
          axdx_nxt = '0;
          nsum_nxt = '0;
          sat_nxt = 1'b0;
        end
      end
      ST_ASQ, ST_ADX: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (state_r == ST_ASQ) begin
            asq_nxt = asq_r + prod_r[63:0];
          end else begin
            axdx_nxt = axdx_r + shp[edfa_pkg::AXW-1:0];
          end
          if (j_r == last_j) begin
            j_nxt = '0;
            state_nxt = (state_r == ST_ASQ) ? ST_ADX : ST_CHK;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      ST_CHK: begin
        if (axdx_r == '0) begin
          lhs_nxt = '0;
          flux_nxt = '0;
          stat_nxt = edfa_pkg::STATUS_ZERO;
          state_nxt = ST_OUT;
        end else begin
          dvd_nxt = {asq_r[63:F], {F{1'b0}}};
          dvs_nxt = 64'(axdx_r[edfa_pkg::AXW-1] ? -axdx_r : axdx_r);
          rem_nxt = '0;
          cnt_nxt = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!rem_sub[64]) begin
          rem_nxt = rem_sub[63:0];
          dvd_nxt = {dvd_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          dvd_nxt = {dvd_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_R;
        end
      end
      ST_R: begin
        if (!axdx_r[edfa_pkg::AXW-1]) begin
          if (|dvd_r[63:31]) begin
            r_nxt = 32'sh7fffffff;
            sat_nxt = 1'b1;
          end else begin
            r_nxt = dvd_r[31:0];
          end
        end else begin
          if ((|dvd_r[63:32]) || (dvd_r[31] && (|dvd_r[30:0]))) begin
            r_nxt = 32'sh80000000;
            sat_nxt = 1'b1;
          end else begin
            r_nxt = -$signed(dvd_r[31:0]);
          end
        end
        phase_nxt = 1'b0;
        state_nxt = ST_LHS;
      end
      ST_LHS, ST_K, ST_T, ST_N, ST_DQ: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          case (state_r)
            ST_LHS: begin
              lhs_nxt = sat_o.val;
              sat_nxt = sat_r || sat_o.hit;
              j_nxt = '0;
              state_nxt = ST_K;
            end
            ST_K: begin
              k_nxt = sat_o.val;
              sat_nxt = sat_r || sat_o.hit;
              state_nxt = ST_T;
            end
            ST_T: begin
              t_nxt = sat_o.val;
              sat_nxt = sat_r || sat_o.hit;
              state_nxt = ST_N;
            end
            ST_N: begin
              nsum_nxt = nsum_r + shp[edfa_pkg::AXW-1:0];
              if (j_r == last_j) begin
                state_nxt = ST_DQ;
              end else begin
                j_nxt = j_r + 2'd1;
                state_nxt = ST_K;
              end
            end
            default: begin
              flux_nxt = sat_o.val;
              stat_nxt = (sat_r || sat_o.hit) ? edfa_pkg::STATUS_SAT : edfa_pkg::STATUS_OK;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      j_r <= '0;
      cnt_r <= '0;
      dims_r <= 2'd3;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lpos_r[i] <= '0;
        lgrad_r[i] <= '0;
      end
      lval_r <= '0;
      lcoeff_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      j_r <= j_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        dims_r <= cfg_wdata;
      end
      if (in_acc && !in_tuser) begin
        for (int i = 0; i < 3; i++) begin
          lpos_r[i] <= in_tdata[32*i +: 32];
          lgrad_r[i] <= in_tdata[96 + 32*i +: 32];
        end
        lval_r <= in_tdata[223:192];
        lcoeff_r <= in_tdata[254:224];
      end
      if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    asq_r <= asq_nxt;
    axdx_r <= axdx_nxt;
    nsum_r <= nsum_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    r_r <= r_nxt;
    lhs_r <= lhs_nxt;
    k_r <= k_nxt;
    t_r <= t_nxt;
    flux_r <= flux_nxt;
    sat_r <= sat_nxt;
    stat_r <= stat_nxt;
    prod_r <= prod_nxt;
    if (in_acc && in_tuser) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= in_tdata[255 + 32*i +: 32];
        d_r[i] <= 33'($signed(in_tdata[32*i +: 32])) - 33'(lpos_r[i]);
        g_r[i] <= 32'((33'($signed(in_tdata[96 + 32*i +: 32])) + 33'(lgrad_r[i])) >>> 1);
      end
      visc_r <= 31'(({1'b0, lcoeff_r} + {1'b0, in_tdata[254:224]}) >> 1);
      dq_r <= 33'($signed(in_tdata[223:192])) - 33'(lval_r);
    end
    if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
      out_tdata_r <= {flux_r, lhs_r};
      out_tuser_r <= stat_r;
    end
  end

endmodule
`default_nettype wire

FILE: design/edfa_checker.sv
`default_nettype none
module edfa_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic [1:0]   out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");

  // a right-node request blocks the next request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("ready after right-node request");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("bad status code");

  // zero area dot distance gives zero values
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == edfa_pkg::STATUS_ZERO |-> out_tdata == 64'd0)
    else $error("nonzero result with zero status");

endmodule

bind edge_diffusion_flux_assembly edfa_checker u_edfa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .in_tuser(in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire

FILE: bench/tb_edge_diffusion_flux_assembly.sv
`timescale 1ns / 1ps
module tb_edge_diffusion_flux_assembly;

  typedef logic signed [127:0] w_t;

  typedef struct {
    logic               kind;
    logic signed [31:0] pos[3];
    logic signed [31:0] grad[3];
    logic signed [31:0] value;
    logic [30:0]        coeff;
    logic signed [31:0] area[3];
  } node_t;

  typedef struct {
    logic [31:0] factor;
    logic [31:0] flux;
    logic [1:0]  status;
  } flux_res_t;

  typedef struct {
    node_t     it;
    bit        typed;
    flux_res_t res;
  } dir_row_t;

  localparam int WATCH_LIMIT = 5000;
  localparam int SETTLE = 150;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [351:0] in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we = 0;
  logic [1:0]   cfg_wdata = '0;

  edge_diffusion_flux_assembly i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .cfg_we, .cfg_wdata
  );

  always #1 clk = ~clk;

  logic [1:0]         mdl_dims = 2'd3;
  logic signed [31:0] lft_pos[3] = '{0, 0, 0};
  logic signed [31:0] lft_grad[3] = '{0, 0, 0};
  logic signed [31:0] lft_value = 0;
  logic [30:0]        lft_coeff = 0;
  bit                 clamp_hit;

  flux_res_t flux_q[$];
  dir_row_t  dir_tab[$];
  int        errors = 0;
  int        in_idle = 0;
  int        out_idle = 0;
  int        quiet = 0;

  function automatic w_t clamp32(w_t v);
    if (v > 128'sd2147483647) begin
      clamp_hit = 1;
      return 128'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      clamp_hit = 1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  // updates the stored left node, returns 1 when a result is due
  function automatic bit edge_flux(node_t it, output flux_res_t res);
    w_t a[3], d[3];
    w_t axdx, asq, mag, q, r, visc, lhs, k, t, g, nsum, dq, flux;
    int n;
    res = '{0, 0, edfa_pkg::STATUS_OK};
    if (!it.kind) begin
      lft_pos = it.pos;
      lft_grad = it.grad;
      lft_value = it.value;
      lft_coeff = it.coeff;
      return 0;
    end
    n = (mdl_dims == 2'd2) ? 2 : 3;
    clamp_hit = 0;
    visc = (w_t'(lft_coeff) + w_t'(it.coeff)) >>> 1;
    axdx = 0;
    asq = 0;
    nsum = 0;
    for (int j = 0; j < n; j++) begin
      a[j] = w_t'(it.area[j]);
      d[j] = w_t'(it.pos[j]) - w_t'(lft_pos[j]);
      asq += a[j] * a[j];
      axdx += (a[j] * d[j]) >>> edfa_pkg::FRAC_BITS;
    end
    if (axdx == 0) begin
      res = '{0, 0, edfa_pkg::STATUS_ZERO};
      return 1;
    end
    asq = (asq >>> edfa_pkg::FRAC_BITS) <<< edfa_pkg::FRAC_BITS;
    mag = axdx < 0 ? -axdx : axdx;
    q = asq / mag;
    if (axdx > 0) begin
      if (q > 128'sd2147483647) begin
        clamp_hit = 1;
        r = 128'sd2147483647;
      end else r = q;
    end else begin
      if (q > 128'sd2147483648) begin
        clamp_hit = 1;
        r = -128'sd2147483648;
      end else r = -q;
    end
    lhs = clamp32(-((visc * r) >>> edfa_pkg::FRAC_BITS));
    for (int j = 0; j < n; j++) begin
      k = clamp32(a[j] - ((r * d[j]) >>> edfa_pkg::FRAC_BITS));
      t = clamp32((visc * k) >>> edfa_pkg::FRAC_BITS);
      g = (w_t'(lft_grad[j]) + w_t'(it.grad[j])) >>> 1;
      nsum += (t * g) >>> edfa_pkg::FRAC_BITS;
    end
    dq = w_t'(it.value) - w_t'(lft_value);
    flux = clamp32(((lhs * dq) >>> edfa_pkg::FRAC_BITS) - nsum);
    res.factor = lhs[31:0];
    res.flux = flux[31:0];
    res.status = clamp_hit ? edfa_pkg::STATUS_SAT : edfa_pkg::STATUS_OK;
    return 1;
  endfunction

  function automatic node_t mk(logic kind, logic [31:0] px, py, pz, gx, gy, gz, v,
                               logic [30:0] c, logic [31:0] ax, ay, az);
    node_t it;
    it.kind = kind;
    it.pos = '{px, py, pz};
    it.grad = '{gx, gy, gz};
    it.value = v;
    it.coeff = c;
    it.area = '{ax, ay, az};
    return it;
  endfunction

  function automatic logic signed [31:0] rval();
    case ($urandom_range(7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return 32'h80000000;
          1: return 32'h7fffffff;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  function automatic node_t rnode(logic kind);
    node_t it;
    it.kind = kind;
    for (int j = 0; j < 3; j++) begin
      it.pos[j] = rval();
      it.grad[j] = rval();
      it.area[j] = rval();
    end
    it.value = rval();
    it.coeff = 31'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h3ffff));
    return it;
  endfunction

  task automatic send(node_t it, bit typed = 0, flux_res_t typed_res = '{0, 0, 0});
    flux_res_t res;
    @(negedge clk);
    while ($urandom_range(99) < in_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= it.kind;
    in_tdata <= {1'b0, it.area[2], it.area[1], it.area[0], it.coeff, it.value,
                 it.grad[2], it.grad[1], it.grad[0], it.pos[2], it.pos[1], it.pos[0]};
    do @(posedge clk); while (!in_tready);
    if (edge_flux(it, res)) flux_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (flux_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_dims(logic [1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    mdl_dims = v;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_idle);

  always @(posedge clk) begin
    flux_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (flux_q.size() == 0) begin
        $display("%0t: result with none pending: %h %h", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        e = flux_q.pop_front();
        if (out_tdata[31:0] !== e.factor || out_tdata[63:32] !== e.flux ||
            out_tuser !== e.status) begin
          $display("%0t: mismatch expected %h %h %0d actual %h %h %0d", $time,
                   e.factor, e.flux, e.status, out_tdata[31:0], out_tdata[63:32],
                   out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    node_t l;
    bit    mid_drained;
    mid_drained = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1;

    dir_tab.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                        '{0, 0, edfa_pkg::STATUS_ZERO}});
    dir_tab.push_back('{mk(0, 32'h10000, 32'h20000, 32'h30000, 32'h8000, 32'hffff0000,
                           32'h18000, 32'h50000, 31'h7fffffff, 0, 0, 0), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(1, 32'h20000, 32'h20000, 32'h30000, 32'h4000, 32'h1000, 0,
                           32'h10000, 31'h7fffffff, 32'h10000, 0, 0), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(1, 32'h10000, 32'h20000, 32'h30000, 1, 2, 3, 4, 31'h10000,
                           32'h10000, 32'h10000, 32'h10000), 1,
                        '{0, 0, edfa_pkg::STATUS_ZERO}});
    dir_tab.push_back('{mk(1, 32'h30000, 32'h20000, 32'h30000, 0, 0, 0, 0, 31'h10000,
                           32'hfffe0000, 32'h8000, 0), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                           0, 0, 0), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
                           32'h80000000, 32'h80000000, 32'h80000000), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff, 0, 0, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(1, 1, 0, 0, 0, 0, 0, 0, 31'h10000, 1, 0, 0), 1,
                        '{0, 0, edfa_pkg::STATUS_ZERO}});
    dir_tab.push_back('{mk(1, 1, 0, 0, 0, 0, 0, 0, 31'h10000, 32'h7fffffff, 0, 0), 0,
                        '{0, 0, 0}});
    dir_tab.push_back('{mk(1, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
                           32'h20000, 31'h20000, 0, 0, 32'h30000), 0, '{0, 0, 0}});
    dir_tab.push_back('{mk(1, 32'hffff0000, 32'h10, 32'h4000, 32'hfff00000, 32'h100000,
                           32'h1, 32'hffff8000, 31'h1, 32'h100, 32'hffffff00, 32'h10000),
                        0, '{0, 0, 0}});

    set_dims(2'd3);
    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      set_dims(ph[1:0]);
      case (ph)
        0: begin in_idle = 0;  out_idle = 0;  end
        1: begin in_idle = 70; out_idle = 0;  end
        2: begin in_idle = 0;  out_idle = 70; end
        default: begin in_idle = 34; out_idle = 34; end
      endcase
      for (int n = 0; n < 340; ) begin
        if ($urandom_range(9) == 0) begin
          send(rnode($urandom_range(1)));
          n++;
        end else begin
          l = rnode(0);
          send(l);
          l = rnode(1);
          send(l);
          n += 2;
          if ($urandom_range(7) == 0) begin
            send(rnode(1));
            n++;
          end
        end
        if (n >= 170 && ph == 1 && !mid_drained) begin
          drain();
          mid_drained = 1;
        end
      end
      set_dims(2'd2);
      in_idle = 0;
      out_idle = 0;
      for (int n = 0; n < 6; n++) send(rnode(n % 2));
    end

    drain();
    if (errors == 0 && flux_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
